FILE: sv/assert_macros.svh
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/bwfm_pkg.sv
package bwfm_pkg;

	// default window depth
	localparam int CAPACITY_DEF = 5;

	// fixed field widths
	localparam int ID_W = 16;
	localparam int H_W  = 10;

	// operation codes
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	// mean quotient magnitude bits, divider bits per cycle and divider steps
	localparam int QW            = 10;
	localparam int DIV_BITS_CYC  = 2;
	localparam int DIV_STEPS     = QW / DIV_BITS_CYC;
	localparam int DSTEP_W       = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

endpackage

FILE: sv/bounded_window_fifo_mean.sv
// Sliding window of up to CAPACITY entries (identifier plus signed height) with mean.
// Input channel: in_valid / in_stall with func, player_id, height. func insert
// appends an entry, dropping the oldest one first when the window is full;
// func remove pops the oldest entry.
// Output channel: out_valid / out_stall, one result transfer per input transfer.
// An insert returns mean_valid with the mean height rounded half up; a remove
// returns removed_valid with the popped identifier, or empty_error on an empty
// window. Unused result fields read as zero.
// Timing: the block takes one item at a time. in_stall stays high while an
// item is worked on: an insert runs the update state, the divider states and
// the finish state, with a pop state first when the window is full; a remove
// runs the pop and finish states, and a remove that finds the window empty
// only the finish state. The result shows on out_valid at the edge where
// in_stall drops. The restoring divider resolves two quotient bits a cycle.
// The entries live in a ring memory with a registered read port; a running
// sum of the heights is kept in a register.
// Reset clears the window (head, count, sum) and the output valid flag; no
// clearing pass is needed. A stalled result is held in the output register
// while the next item is already taken and worked on; that next result then
// waits, with in_stall high, until the output register is free.
module bounded_window_fifo_mean
	import bwfm_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   func,
	input  logic [ID_W-1:0]        player_id,
	input  logic signed [H_W-1:0]  height,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   mean_valid,
	output logic signed [H_W-1:0]  mean_height,
	output logic                   removed_valid,
	output logic [ID_W-1:0]        removed_id,
	output logic                   empty_error
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int TW    = CNT_W + 1;
	localparam int SUM_W = H_W + CNT_W;
	localparam int NUM_W = SUM_W + 2;
	localparam int DEN_W = CNT_W + 1;
	localparam int DW    = NUM_W + QW;
	localparam int ENT_W = ID_W + H_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_POP  = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]              state_q;
	logic                    func_q;
	logic [ID_W-1:0]         pid_q;
	logic signed [H_W-1:0]   h_q;
	logic [IDX_W-1:0]        head_q;
	logic [CNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [ENT_W-1:0]        rd_q;
	logic [ENT_W-1:0]        ring_mem [CAPACITY];

	logic                    neg_q;
	logic [NUM_W-1:0]        rem_q;
	logic [DW-1:0]           dsh_q;
	logic [QW-1:0]           quo_q;
	logic [DSTEP_W-1:0]      step_q;

	logic                    res_mv_q;
	logic signed [H_W-1:0]   res_mean_q;
	logic                    res_rv_q;
	logic [ID_W-1:0]         res_id_q;
	logic                    res_err_q;

	logic                    out_valid_q;
	logic                    out_mv_q;
	logic signed [H_W-1:0]   out_mean_q;
	logic                    out_rv_q;
	logic [ID_W-1:0]         out_id_q;
	logic                    out_err_q;

	logic                    in_acc;
	logic                    out_acc;
	logic                    out_free;
	logic                    full;
	logic                    empty;
	logic                    wr_en;
	logic [TW-1:0]           tail_w;
	logic [TW-1:0]           tail_m;
	logic [IDX_W-1:0]        wr_addr;
	logic [IDX_W-1:0]        head_inc;
	logic signed [H_W-1:0]   rd_h;
	logic [ID_W-1:0]         rd_id;
	logic signed [SUM_W-1:0] sum_pop;
	logic [CNT_W-1:0]        cnt_n;
	logic signed [SUM_W-1:0] sum_n;
	logic signed [NUM_W-1:0] num_w;
	logic [NUM_W-1:0]        num_mag;
	logic [DEN_W-1:0]        den;
	logic [NUM_W-1:0]        r_nx;
	logic [DW-1:0]           d_nx;
	logic [QW-1:0]           q_nx;
	logic [QW:0]             q_ext;
	logic [QW:0]             mean_w;

	// handshakes
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	// slot after the newest entry
	assign tail_w  = TW'(head_q) + TW'(count_q);
	assign tail_m  = (tail_w >= TW'(CAPACITY)) ? (tail_w - TW'(CAPACITY)) : tail_w;
	assign wr_addr = tail_m[IDX_W-1:0];
	assign wr_en   = (state_q == ST_UPD);

	assign head_inc = (head_q == IDX_W'(CAPACITY - 1)) ? '0 : (head_q + 1'b1);

	// popped entry from the ring read data
	assign rd_h    = rd_q[H_W-1:0];
	assign rd_id   = rd_q[ENT_W-1:H_W];
	assign sum_pop = sum_q - {{(SUM_W-H_W){rd_h[H_W-1]}}, rd_h};

	// new sum and rounding numerator 2*sum + count over denominator 2*count
	assign cnt_n   = count_q + 1'b1;
	assign sum_n   = sum_q + {{(SUM_W-H_W){h_q[H_W-1]}}, h_q};
	assign num_w   = {sum_n[SUM_W-1], sum_n, 1'b0} + NUM_W'(cnt_n);
	assign num_mag = num_w[NUM_W-1] ? (~num_w + 1'b1) : num_w;
	assign den     = {cnt_n, 1'b0};

	// restoring divider, two quotient bits a cycle
	always_comb begin
		r_nx = rem_q;
		d_nx = dsh_q;
		q_nx = quo_q;
		for (int k = 0; k < DIV_BITS_CYC; k++) begin
			if (DW'(r_nx) >= d_nx) begin
				r_nx = r_nx - d_nx[NUM_W-1:0];
				q_nx = {q_nx[QW-2:0], 1'b1};
			end else begin
				q_nx = {q_nx[QW-2:0], 1'b0};
			end
			d_nx = d_nx >> 1;
		end
	end

	// floor of the signed quotient from magnitude and remainder
	assign q_ext  = {1'b0, q_nx};
	assign mean_w = neg_q ? ((~q_ext + 1'b1) - (QW+1)'(r_nx != '0)) : q_ext;

	// ring memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_addr] <= {pid_q, h_q};
		end
		if (in_acc) begin
			rd_q <= ring_mem[head_q];
		end
	end

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (func == FUNC_REMOVE) begin
							state_q <= empty ? ST_FIN : ST_POP;
						end else begin
							state_q <= full ? ST_POP : ST_UPD;
						end
					end
				end
				ST_POP: begin
					sum_q   <= sum_pop;
					head_q  <= head_inc;
					count_q <= count_q - 1'b1;
					state_q <= (func_q == FUNC_REMOVE) ? ST_FIN : ST_UPD;
				end
				ST_UPD: begin
					sum_q   <= sum_n;
					count_q <= cnt_n;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item, divider and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q     <= func;
			pid_q      <= player_id;
			h_q        <= height;
			res_mv_q   <= (func == FUNC_INSERT);
			res_mean_q <= '0;
			res_rv_q   <= 1'b0;
			res_id_q   <= '0;
			res_err_q  <= (func == FUNC_REMOVE) && empty;
		end
		if ((state_q == ST_POP) && (func_q == FUNC_REMOVE)) begin
			res_rv_q <= 1'b1;
			res_id_q <= rd_id;
		end
		if (state_q == ST_UPD) begin
			neg_q  <= num_w[NUM_W-1];
			rem_q  <= num_mag;
			dsh_q  <= DW'(den) << (QW - 1);
			quo_q  <= '0;
			step_q <= DSTEP_W'(DIV_STEPS - 1);
		end
		if (state_q == ST_DIV) begin
			rem_q  <= r_nx;
			dsh_q  <= d_nx;
			quo_q  <= q_nx;
			step_q <= step_q - 1'b1;
			if (step_q == '0) begin
				res_mean_q <= mean_w[H_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			out_mv_q   <= res_mv_q;
			out_mean_q <= res_mean_q;
			out_rv_q   <= res_rv_q;
			out_id_q   <= res_id_q;
			out_err_q  <= res_err_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign mean_valid    = out_mv_q;
	assign mean_height   = out_mean_q;
	assign removed_valid = out_rv_q;
	assign removed_id    = out_id_q;
	assign empty_error   = out_err_q;

endmodule

FILE: sv/bwfm_checker.sv
`include "assert_macros.svh"

module bwfm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        func,
	input logic [15:0] player_id,
	input logic [9:0]  height,
	input logic        out_valid,
	input logic        out_stall,
	input logic        mean_valid,
	input logic [9:0]  mean_height,
	input logic        removed_valid,
	input logic [15:0] removed_id,
	input logic        empty_error
);

	logic        one_kind;
	logic        id_unused;
	logic        out_held;
	logic [28:0] res_bus;

	// exactly one result flag per result transfer
	assign one_kind = (mean_valid ^ removed_valid ^ empty_error)
		&& !(mean_valid && removed_valid && empty_error);

	assign id_unused = out_valid && !removed_valid;
	assign out_held  = out_valid && out_stall;
	assign res_bus   = {mean_valid, mean_height, removed_valid, removed_id, empty_error};

	`ASSERT_IMPLY(a_one_kind, clk, arst_n, out_valid, one_kind, "result flags not one-hot")

	// unused removed_id reads as zero
	`ASSERT_IMPLY(a_id_zero, clk, arst_n, id_unused, removed_id == '0, "removed_id not zero")

	// one item at a time: the block is busy right after a transfer in
	`ASSERT_NEXT(a_busy, clk, arst_n, in_valid && !in_stall, in_stall, "input taken while busy")

	// stalled result holds
	`ASSERT_NEXT(a_hold, clk, arst_n, out_held, out_valid && $stable(res_bus), "stall not held")

endmodule

bind bounded_window_fifo_mean bwfm_checker u_bwfm_checker (.*);
